FILE: rtl/ecl_pkg.sv
// ============================================================================
// ecl_pkg
// Shared types and constants for the escaped command line parser.
// ============================================================================
package ecl_pkg;

    localparam int AUX_BYTES  = 512;
    localparam int CNT_W      = $clog2(AUX_BYTES + 1);
    localparam int IDX_W      = 9;
    localparam int LEN_W      = 10;
    localparam int FIFO_DEPTH = 4;
    localparam int FPTR_W     = $clog2(FIFO_DEPTH);

    localparam logic [7:0] BIN_MASK   = 8'b1000_0000;
    localparam logic [7:0] PIN_MASK   = 8'b0011_1111;
    localparam logic [7:0] LEVEL_MASK = 8'b0100_0000;
    localparam logic [7:0] CH_NL      = 8'h0A;
    localparam logic [7:0] CH_BSLASH  = 8'h5C;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [1:0] AUX_FRAG   = 2'd3;

    typedef enum logic [1:0] {
        KIND_BIN   = 2'd0,
        KIND_STORE = 2'd1,
        KIND_DONE  = 2'd2
    } ecl_kind_t;

    typedef enum logic [1:0] {
        PH_SKIP   = 2'd0,
        PH_DIGITS = 2'd1,
        PH_STOP   = 2'd2
    } ecl_phase_t;

    typedef struct packed {
        ecl_kind_t          kind;
        logic [5:0]         wr_pin;
        logic               wr_level;
        logic [IDX_W-1:0]   aux_index;
        logic [7:0]         aux_byte;
        logic               aux_dropped;
        logic signed [31:0] cmd_code;
        logic signed [31:0] cmd_pin;
        logic signed [31:0] cmd_value;
        logic [LEN_W-1:0]   aux_length;
    } ecl_res_t;

    typedef struct packed {
        logic     two;
        ecl_res_t res;
    } ecl_entry_t;

    typedef struct packed {
        logic       push;
        ecl_entry_t data;
    } ecl_push_t;

    typedef struct packed {
        logic       empty;
        ecl_entry_t data;
    } ecl_head_t;

endpackage

FILE: rtl/ecl_if.sv
// ============================================================================
// ecl_if
// Valid/ready channels for received bytes and for parser results.
// ============================================================================
interface ecl_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ecl_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         kind;
    logic [5:0]         wr_pin;
    logic               wr_level;
    logic [8:0]         aux_index;
    logic [7:0]         aux_byte;
    logic               aux_dropped;
    logic signed [31:0] cmd_code;
    logic signed [31:0] cmd_pin;
    logic signed [31:0] cmd_value;
    logic [9:0]         aux_length;
    logic               last;

    modport source (output valid, output kind, output wr_pin, output wr_level,
                    output aux_index, output aux_byte, output aux_dropped,
                    output cmd_code, output cmd_pin, output cmd_value,
                    output aux_length, output last, input ready);
    modport sink   (input valid, input kind, input wr_pin, input wr_level,
                    input aux_index, input aux_byte, input aux_dropped,
                    input cmd_code, input cmd_pin, input cmd_value,
                    input aux_length, input last, output ready);
endinterface

FILE: rtl/ecl_front.sv
// ============================================================================
// ecl_front
// Accepts received bytes, tracks line state and decodes the numeric fields,
// and queues one entry for every byte that produces results.
// ============================================================================
module ecl_front
    import ecl_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    ecl_in_if.sink    rx,
    input  logic      full,
    output ecl_push_t push
);

    logic [1:0]       frag_reg, frag_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             esc_reg, esc_next;
    ecl_phase_t       phase_reg, phase_next;
    logic             neg_reg, neg_next;
    logic [31:0]      num_reg  [0:2];
    logic [31:0]      num_next [0:2];

    logic             accept;
    logic [7:0]       c;
    logic             is_bin;
    logic             app_en;
    logic [7:0]       app_val;
    logic             line_end;
    logic             dot_adv;
    logic [31:0]      base;
    logic [31:0]      times10;
    logic [31:0]      digit;
    ecl_phase_t       ph_eff;
    logic             neg_eff;
    logic             st_en;
    logic             cmd_en;
    ecl_entry_t       ent;

    assign rx.ready = !full;
    assign accept   = rx.valid && rx.ready;
    assign c        = rx.rx_byte;
    assign is_bin   = (frag_reg == 2'd0) && (cnt_reg == '0) && ((c & BIN_MASK) != 8'd0);

    always_comb
    begin
        app_en   = 1'b0;
        app_val  = c;
        line_end = 1'b0;
        dot_adv  = 1'b0;
        esc_next = esc_reg;
        if (is_bin)
        begin
            app_en = 1'b0;
        end
        else if (c == CH_NL || c == CH_BSLASH)
        begin
            if (esc_reg)
            begin
                app_en   = 1'b1;
                esc_next = 1'b0;
            end
            else if (c == CH_NL)
            begin
                app_en   = 1'b1;
                app_val  = 8'd0;
                line_end = 1'b1;
            end
            else
            begin
                esc_next = 1'b1;
            end
        end
        else if (c == CH_DOT)
        begin
            esc_next = 1'b0;
            app_en   = 1'b1;
            if (frag_reg != AUX_FRAG)
            begin
                app_val = 8'd0;
                dot_adv = 1'b1;
            end
        end
        else
        begin
            esc_next = 1'b0;
            app_en   = 1'b1;
        end
    end

    always_comb
    begin
        base       = (cnt_reg == '0) ? 32'd0 : num_reg[frag_reg];
        ph_eff     = (cnt_reg == '0) ? PH_SKIP : phase_reg;
        neg_eff    = (cnt_reg == '0) ? 1'b0 : neg_reg;
        times10    = (base << 3) + (base << 1);
        digit      = {24'd0, app_val - CH_ZERO};
        frag_next  = frag_reg;
        cnt_next   = cnt_reg;
        phase_next = phase_reg;
        neg_next   = neg_reg;
        st_en      = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            num_next[i] = num_reg[i];
        end

        ent = '0;

        if (app_en)
        begin
            if (frag_reg != AUX_FRAG)
            begin
                phase_next = ph_eff;
                neg_next   = neg_eff;
                num_next[frag_reg] = base;
                if (ph_eff == PH_SKIP && (app_val inside {8'h20, [8'h09:8'h0D]}))
                begin
                    phase_next = PH_SKIP;
                end
                else if (ph_eff == PH_SKIP && (app_val == CH_PLUS || app_val == CH_MINUS))
                begin
                    neg_next   = (app_val == CH_MINUS);
                    phase_next = PH_DIGITS;
                end
                else if (ph_eff != PH_STOP && app_val >= CH_ZERO && app_val <= CH_NINE)
                begin
                    num_next[frag_reg] = neg_eff ? (times10 - digit) : (times10 + digit);
                    phase_next         = PH_DIGITS;
                end
                else
                begin
                    phase_next = PH_STOP;
                end
                if (cnt_reg < CNT_W'(AUX_BYTES))
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            else
            begin
                st_en            = 1'b1;
                ent.res.kind     = KIND_STORE;
                ent.res.aux_byte = app_val;
                if (cnt_reg < CNT_W'(AUX_BYTES))
                begin
                    ent.res.aux_index = cnt_reg[IDX_W-1:0];
                    cnt_next          = cnt_reg + 1'b1;
                end
                else
                begin
                    ent.res.aux_dropped = 1'b1;
                end
            end
        end

        cmd_en = line_end && (frag_reg != 2'd0 || cnt_reg != '0);
        if (cmd_en)
        begin
            ent.res.cmd_code  = num_next[0];
            ent.res.cmd_pin   = num_next[1];
            ent.res.cmd_value = num_next[2];
            if (frag_reg == AUX_FRAG)
            begin
                ent.res.aux_length = LEN_W'(cnt_reg);
            end
            if (st_en)
            begin
                ent.two = 1'b1;
            end
            else
            begin
                ent.res.kind = KIND_DONE;
            end
        end

        if (is_bin)
        begin
            ent.res.kind     = KIND_BIN;
            ent.res.wr_pin   = 6'(c & PIN_MASK);
            ent.res.wr_level = (c & LEVEL_MASK) != 8'd0;
        end

        if (line_end)
        begin
            frag_next = 2'd0;
            cnt_next  = '0;
        end
        else if (dot_adv)
        begin
            frag_next = frag_reg + 1'b1;
            cnt_next  = '0;
        end
    end

    assign push.push = accept && (is_bin || st_en || cmd_en);
    assign push.data = ent;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frag_reg  <= 2'd0;
            cnt_reg   <= '0;
            esc_reg   <= 1'b0;
            phase_reg <= PH_SKIP;
            neg_reg   <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                num_reg[i] <= 32'd0;
            end
        end
        else if (accept)
        begin
            frag_reg  <= frag_next;
            cnt_reg   <= cnt_next;
            esc_reg   <= esc_next;
            phase_reg <= phase_next;
            neg_reg   <= neg_next;
            for (int i = 0; i < 3; i++)
            begin
                num_reg[i] <= num_next[i];
            end
        end
    end

endmodule

FILE: rtl/ecl_fifo.sv
// ============================================================================
// ecl_fifo
// Short queue of decoded entries between the front and back parts.
// ============================================================================
module ecl_fifo
    import ecl_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  ecl_push_t push,
    output logic      full,
    input  logic      pop,
    output ecl_head_t head
);

    ecl_entry_t        mem [0:FIFO_DEPTH-1];
    logic [FPTR_W-1:0] wr_ptr_reg;
    logic [FPTR_W-1:0] rd_ptr_reg;
    logic [FPTR_W:0]   count_reg;
    logic              do_push;
    logic              do_pop;

    assign full       = (count_reg == (FPTR_W+1)'(FIFO_DEPTH));
    assign head.empty = (count_reg == '0);
    assign head.data  = mem[rd_ptr_reg];
    assign do_push    = push.push && !full;
    assign do_pop     = pop && !head.empty;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

FILE: rtl/ecl_back.sv
// ============================================================================
// ecl_back
// Drains queued entries into the registered result channel, splitting an
// entry that carries both an aux store and a command into two transactions.
// ============================================================================
module ecl_back
    import ecl_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  ecl_head_t head,
    output logic      pop,
    ecl_out_if.source res
);

    logic     valid_reg, valid_next;
    logic     second_reg, second_next;
    ecl_res_t data_reg, data_next;
    logic     last_reg, last_next;
    logic     load;

    assign load = !valid_reg || res.ready;

    always_comb
    begin
        valid_next  = valid_reg;
        second_next = second_reg;
        data_next   = data_reg;
        last_next   = last_reg;
        pop         = 1'b0;
        if (load)
        begin
            valid_next = !head.empty;
            if (!head.empty)
            begin
                data_next = head.data.res;
                last_next = 1'b1;
                if (head.data.two && !second_reg)
                begin
                    data_next.kind       = KIND_STORE;
                    data_next.cmd_code   = '0;
                    data_next.cmd_pin    = '0;
                    data_next.cmd_value  = '0;
                    data_next.aux_length = '0;
                    last_next            = 1'b0;
                    second_next          = 1'b1;
                end
                else
                begin
                    if (head.data.two)
                    begin
                        data_next.kind        = KIND_DONE;
                        data_next.aux_index   = '0;
                        data_next.aux_byte    = '0;
                        data_next.aux_dropped = 1'b0;
                    end
                    second_next = 1'b0;
                    pop         = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= 1'b0;
            second_reg <= 1'b0;
        end
        else
        begin
            valid_reg  <= valid_next;
            second_reg <= second_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        last_reg <= last_next;
    end

    assign res.valid       = valid_reg;
    assign res.kind        = data_reg.kind;
    assign res.wr_pin      = data_reg.wr_pin;
    assign res.wr_level    = data_reg.wr_level;
    assign res.aux_index   = data_reg.aux_index;
    assign res.aux_byte    = data_reg.aux_byte;
    assign res.aux_dropped = data_reg.aux_dropped;
    assign res.cmd_code    = data_reg.cmd_code;
    assign res.cmd_pin     = data_reg.cmd_pin;
    assign res.cmd_value   = data_reg.cmd_value;
    assign res.aux_length  = data_reg.aux_length;
    assign res.last        = last_reg;

endmodule

FILE: rtl/escaped_command_line_parser.sv
// ============================================================================
// escaped_command_line_parser
// Byte-serial parser for binary pin writes and escaped "cmd.pin.val.aux"
// text lines, with decoded numeric fields and aux byte stores.
// ============================================================================
// Channel   Role   Transaction
// rx        sink   one received byte (rx_byte)
// res       source one result: pin write, aux store or command complete
//
// A byte is taken every cycle while the four-entry queue has room; its line
// state and numeric fields update in that same cycle.
// The result register sends one transaction per cycle while not stalled, so
// a newline in the aux field yields two results, sent as two transactions.
// Reset clears the line state and the queue; no clearing pass is needed.
// A stalled result channel fills the queue and then holds rx.ready low.
module escaped_command_line_parser
    import ecl_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    ecl_in_if.sink    rx,
    ecl_out_if.source res
);

    ecl_push_t push;
    ecl_head_t head;
    logic      full;
    logic      pop;

    ecl_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx),
        .full  (full),
        .push  (push)
    );

    ecl_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (full),
        .pop   (pop),
        .head  (head)
    );

    ecl_back u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .head  (head),
        .pop   (pop),
        .res   (res)
    );

endmodule

FILE: rtl/ecl_checker.sv
// ============================================================================
// ecl_checker
// Port-level checks on the result channel of the parser.
// ============================================================================
module ecl_checker
    import ecl_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               valid,
    input logic               ready,
    input logic [1:0]         kind,
    input logic [8:0]         aux_index,
    input logic               aux_dropped,
    input logic signed [31:0] cmd_code,
    input logic [9:0]         aux_length,
    input logic               last
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !ready |=> valid && $stable(kind) && $stable(last))
        else $error("Result changed while stalled.");

    a_first_is_store: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !last |-> kind == KIND_STORE)
        else $error("Only an aux store may precede another result of a byte.");

    a_second_done: assert property (@(posedge clk) disable iff (!rst_n)
        valid && ready && !last |=> valid && kind == KIND_DONE && last)
        else $error("A command result must follow the terminator store.");

    a_drop_index: assert property (@(posedge clk) disable iff (!rst_n)
        valid && aux_dropped |-> aux_index == 9'd0 && kind == KIND_STORE)
        else $error("A dropped aux byte carries a nonzero index.");

    a_bin_clean: assert property (@(posedge clk) disable iff (!rst_n)
        valid && kind == KIND_BIN |-> cmd_code == 32'sd0 && aux_length == 10'd0 && last)
        else $error("A binary write carries command fields.");

endmodule

bind escaped_command_line_parser ecl_checker u_ecl_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .valid       (res.valid),
    .ready       (res.ready),
    .kind        (res.kind),
    .aux_index   (res.aux_index),
    .aux_dropped (res.aux_dropped),
    .cmd_code    (res.cmd_code),
    .aux_length  (res.aux_length),
    .last        (res.last)
);
